// File: hw/rtl/clt_pkg.sv
package clt_pkg;

  localparam int CoordW = 8;
  localparam int MagW   = 16;
  localparam int CoefAW = 9;
  localparam int CoefCW = 17;
  localparam int GcdW   = 8;

  typedef struct packed {
    logic [MagW-1:0] diff;
    logic            borrow;
  } sub_res_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_GCD  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    DIV_A = 2'd0,
    DIV_B = 2'd1,
    DIV_C = 2'd2
  } div_sel_e;

endpackage

// File: hw/rtl/canonical_line_through_two_points.sv
// Canonical line through two grid points.
// Input: raise start with the four coordinates while busy is low; the item
// is taken at that edge. Coordinates wrap modulo GRID_SIZE.
// Output: valid_o is high for exactly one cycle with coef_a_o, coef_b_o,
// coef_c_o and degenerate_o. The receiver cannot stall; the result must be
// captured in that cycle.
// Timing: coinciding points put the degenerate result on the outputs in the
// cycle right after the accept edge, and busy stays low, so such items can
// follow every cycle. Otherwise busy is high until the result cycle, through
// S_MUL1, S_MUL2, the shift, swap and subtract steps of both gcd passes,
// the division steps and S_DONE. The next item can be taken at the edge that
// ends the result cycle. The work is done by one shared 16-bit subtractor:
// binary gcd of |A|,|B|, then of that with |C|, followed by 8 + 8 + 16
// restoring division steps. Two 8x8 products, in S_MUL1 and S_MUL2, form C
// before the gcd loop.
// Reset: asynchronous, clears the sequencer and the strobe; no pending
// item survives reset.
module canonical_line_through_two_points import clt_pkg::*; #(
  parameter int GRID_SIZE = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic [CoordW-1:0]        first_x_i,
  input  logic [CoordW-1:0]        first_y_i,
  input  logic [CoordW-1:0]        second_x_i,
  input  logic [CoordW-1:0]        second_y_i,
  output logic                     busy,
  output logic                     valid_o,
  output logic signed [CoefAW-1:0] coef_a_o,
  output logic signed [CoefAW-1:0] coef_b_o,
  output logic signed [CoefCW-1:0] coef_c_o,
  output logic                     degenerate_o
);

  localparam int NumCodes = 2 ** CoordW;

  typedef logic [NumCodes-1:0][CoordW-1:0] wrap_lut_t;

  function automatic wrap_lut_t build_wrap_lut();
    wrap_lut_t lut;
    for (int i = 0; i < NumCodes; i++) begin
      lut[i] = CoordW'(i % GRID_SIZE);
    end
    return lut;
  endfunction

  localparam wrap_lut_t WrapLut = build_wrap_lut();

  state_e state_q, state_d;
  logic   valid_q;

  logic [CoordW-1:0] wpx, wpy, wqx, wqy;
  logic              accept, degen_in;

  logic [CoordW-1:0]        px_q, py_q, qx_q, qy_q;
  logic signed [CoefAW-1:0] a_q, b_q;
  logic signed [CoefCW-1:0] c_q;
  logic [MagW-1:0]          prod_q, prod2;

  logic [MagW-1:0]   u_q, v_q, gval;
  logic [3:0]        k_q;
  logic              phase_q;
  logic [GcdW-1:0]   g_q;
  div_sel_e          sel_q;
  logic [3:0]        cnt_q;
  logic [MagW-1:0]   dv_q, quo_q, quo_next;
  logic [GcdW-1:0]   rem_q, qa_q, qb_q;
  logic [GcdW:0]     trial;

  logic [CoefAW-1:0] neg_a, neg_b;
  logic [CoefCW-1:0] neg_c;
  logic [GcdW-1:0]   mag_a, mag_b;
  logic [MagW-1:0]   mag_c;

  logic              flip, out_a_neg, out_b_neg, out_c_neg;
  logic [CoefAW-1:0] out_a, out_b;
  logic [CoefCW-1:0] out_c;

  logic [MagW-1:0] op_a, op_b;
  sub_res_t        sub_res;

  logic signed [CoefAW-1:0] coef_a_q, coef_b_q;
  logic signed [CoefCW-1:0] coef_c_q;
  logic                     degenerate_q;

  clt_sub u_sub (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (sub_res)
  );

  assign wpx = WrapLut[first_x_i];
  assign wpy = WrapLut[first_y_i];
  assign wqx = WrapLut[second_x_i];
  assign wqy = WrapLut[second_y_i];

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign degen_in = (wpx == wqx) && (wpy == wqy);

  assign neg_a = -a_q;
  assign neg_b = -b_q;
  assign neg_c = -c_q;
  assign mag_a = a_q[CoefAW-1] ? neg_a[GcdW-1:0] : a_q[GcdW-1:0];
  assign mag_b = b_q[CoefAW-1] ? neg_b[GcdW-1:0] : b_q[GcdW-1:0];
  assign mag_c = c_q[CoefCW-1] ? neg_c[MagW-1:0] : c_q[MagW-1:0];

  assign prod2 = qx_q * py_q;
  assign gval  = (u_q | v_q) << k_q;

  assign trial    = {rem_q, dv_q[MagW-1]};
  assign quo_next = {quo_q[MagW-2:0], ~sub_res.borrow};

  always_comb begin
    unique case (state_q)
      S_GCD: begin
        op_a = u_q;
        op_b = v_q;
      end
      S_DIV: begin
        op_a = MagW'(trial);
        op_b = MagW'(g_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // canonical sign: A positive, or A zero and B positive
  assign flip      = a_q[CoefAW-1] || ((a_q == '0) && b_q[CoefAW-1]);
  assign out_a_neg = a_q[CoefAW-1] ^ flip;
  assign out_b_neg = b_q[CoefAW-1] ^ flip;
  assign out_c_neg = c_q[CoefCW-1] ^ flip;
  assign out_a     = CoefAW'(qa_q);
  assign out_b     = CoefAW'(qb_q);
  assign out_c     = CoefCW'(quo_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !degen_in) state_d = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_GCD;
      S_GCD: begin
        if (((u_q == '0) || (v_q == '0)) && phase_q) state_d = S_DIV;
      end
      S_DIV: begin
        if ((cnt_q == '0) && (sel_q == DIV_C)) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (accept && degen_in) || (state_q == S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          px_q <= wpx;
          py_q <= wpy;
          qx_q <= wqx;
          qy_q <= wqy;
          a_q  <= CoefAW'(wqy) - CoefAW'(wpy);
          b_q  <= CoefAW'(wpx) - CoefAW'(wqx);
          if (degen_in) begin
            coef_a_q     <= '0;
            coef_b_q     <= '0;
            coef_c_q     <= '0;
            degenerate_q <= 1'b1;
          end
        end
      end
      S_MUL1: begin
        prod_q <= qy_q * px_q;
      end
      S_MUL2: begin
        // C = -(A*px + B*py) = qx*py - qy*px
        c_q     <= CoefCW'(prod2) - CoefCW'(prod_q);
        u_q     <= MagW'(mag_a);
        v_q     <= MagW'(mag_b);
        k_q     <= '0;
        phase_q <= 1'b0;
      end
      S_GCD: begin
        if ((u_q == '0) || (v_q == '0)) begin
          if (!phase_q) begin
            u_q     <= gval;
            v_q     <= mag_c;
            k_q     <= '0;
            phase_q <= 1'b1;
          end else begin
            g_q   <= gval[GcdW-1:0];
            sel_q <= DIV_A;
            cnt_q <= 4'(GcdW - 1);
            dv_q  <= {mag_a, {(MagW-GcdW){1'b0}}};
            rem_q <= '0;
            quo_q <= '0;
          end
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 4'd1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (sub_res.borrow) begin
          // keep u >= v so a stored difference is never negative
          u_q <= v_q;
          v_q <= u_q;
        end else begin
          u_q <= sub_res.diff >> 1;
        end
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          rem_q <= sub_res.borrow ? trial[GcdW-1:0] : sub_res.diff[GcdW-1:0];
          quo_q <= quo_next;
          dv_q  <= dv_q << 1;
          cnt_q <= cnt_q - 4'd1;
        end else begin
          case (sel_q)
            DIV_A: begin
              qa_q  <= quo_next[GcdW-1:0];
              sel_q <= DIV_B;
              cnt_q <= 4'(GcdW - 1);
              dv_q  <= {mag_b, {(MagW-GcdW){1'b0}}};
              rem_q <= '0;
              quo_q <= '0;
            end
            DIV_B: begin
              qb_q  <= quo_next[GcdW-1:0];
              sel_q <= DIV_C;
              cnt_q <= 4'(MagW - 1);
              dv_q  <= mag_c;
              rem_q <= '0;
              quo_q <= '0;
            end
            default: begin
              quo_q <= quo_next;
            end
          endcase
        end
      end
      S_DONE: begin
        coef_a_q     <= out_a_neg ? -out_a : out_a;
        coef_b_q     <= out_b_neg ? -out_b : out_b;
        coef_c_q     <= out_c_neg ? -out_c : out_c;
        degenerate_q <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign valid_o      = valid_q;
  assign coef_a_o     = coef_a_q;
  assign coef_b_o     = coef_b_q;
  assign coef_c_o     = coef_c_q;
  assign degenerate_o = degenerate_q;

  a_degen_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && degen_in) |=> (valid_o && degenerate_o))
    else $error("coinciding points did not give a degenerate item");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |->
      ((coef_a_o == '0) && (coef_b_o == '0) && (coef_c_o == '0)))
    else $error("degenerate item with nonzero coefficients");

  a_canon_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !degenerate_o) |->
      (!coef_a_o[CoefAW-1] &&
       ((coef_a_o != '0) || (!coef_b_o[CoefAW-1] && (coef_b_o != '0)))))
    else $error("result item not in canonical sign");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (g_q != '0))
    else $error("division by zero gcd");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (valid_o && !busy))
    else $error("finished item not delivered");

endmodule

// File: hw/rtl/clt_sub.sv
module clt_sub import clt_pkg::*; (
  input  logic [MagW-1:0] op_a_i,
  input  logic [MagW-1:0] op_b_i,
  output sub_res_t        res_o
);

  logic [MagW:0] full;

  assign full         = {1'b0, op_a_i} - {1'b0, op_b_i};
  assign res_o.diff   = full[MagW-1:0];
  assign res_o.borrow = full[MagW];

endmodule
